// ===== rtl/irpd_pkg.sv =====
// Shared constants and types for the IR pulse-width frame decoder.
package irpd_pkg;

  localparam int STORE_BITS = 24;

  localparam int WIDTH_W = 12;
  localparam int ZERO_W  = 11;
  localparam int TOL_W   = 10;
  localparam int HDR_W   = 12;
  localparam int CNT_W   = 8;
  localparam int POS_W   = 5;
  localparam int LEN_W   = 2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_ZERO_WIDTH = 2'd0;
  localparam logic [1:0] REG_TOLERANCE  = 2'd1;
  localparam logic [1:0] REG_HEADER_MIN = 2'd2;

  localparam logic [ZERO_W-1:0] ZERO_WIDTH_RST = 11'd600;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 10'd200;
  localparam logic [HDR_W-1:0]  HEADER_MIN_RST = 12'd1800;

  localparam logic [POS_W-1:0] PARITY_POS_NONE  = 5'd0;
  localparam logic [POS_W-1:0] PARITY_POS_TWO   = 5'd16;
  localparam logic [POS_W-1:0] PARITY_POS_THREE = 5'd24;

  localparam logic [LEN_W-1:0] FRAME_LEN_NONE  = 2'd0;
  localparam logic [LEN_W-1:0] FRAME_LEN_TWO   = 2'd2;
  localparam logic [LEN_W-1:0] FRAME_LEN_THREE = 2'd3;

  localparam logic [CNT_W-1:0] SHORT_FRAME_MAX = 8'd15;
  localparam logic [CNT_W-1:0] COUNT_MAX       = 8'd255;
  localparam logic [7:0]       CAPTURE_LIMIT   = 8'd128;

  typedef logic [STORE_BITS-1:0] store_t;

endpackage

// ===== rtl/irpd_in_if.sv =====
// Input channel: one measured pulse width per item.
interface irpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [irpd_pkg::WIDTH_W-1:0]  pulse_width;

  modport source (output valid, output pulse_width, input ready);
  modport sink   (input valid, input pulse_width, output ready);
endinterface

// ===== rtl/irpd_out_if.sv =====
// Result channel: one decoded frame per item.
interface irpd_out_if;
  logic       valid;
  logic       ready;
  logic       parity_ok;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] bits_received;
  logic       is_capture;
  logic [1:0] team;

  modport source (output valid, output parity_ok, output first_byte, output second_byte,
                  output third_byte, output bits_received, output is_capture, output team,
                  input ready);
  modport sink   (input valid, input parity_ok, input first_byte, input second_byte,
                  input third_byte, input bits_received, input is_capture, input team,
                  output ready);
endinterface

// ===== rtl/ir_pulse_width_frame_decoder.sv =====
// IR pulse-width frame decoder: input register, decode logic, result register.
// A result is loaded into the result register when the staged closing timeout item advances.
// Throughput: one item per cycle; the input stalls only while a result waits
// in the full result register and the staged item would produce another.
// Reset: synchronous, active-low rst_n; clears frame state, stages and registers
// to their power-up values (zero_width 600, tolerance 200, header_min 1800).
module ir_pulse_width_frame_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  irpd_in_if.sink                             in_ch,
  irpd_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [irpd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [irpd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int SB = irpd_pkg::STORE_BITS;

  logic [irpd_pkg::ZERO_W-1:0] zero_width_r;
  logic [irpd_pkg::TOL_W-1:0]  tolerance_r;
  logic [irpd_pkg::HDR_W-1:0]  header_min_r;

  logic                          s1_valid_r;
  logic [irpd_pkg::WIDTH_W-1:0]  s1_width_r;

  logic                        in_frame_r, in_frame_nxt;
  logic [irpd_pkg::CNT_W-1:0]  bit_index_r, bit_index_nxt;
  irpd_pkg::store_t            store_r, store_nxt;
  logic [irpd_pkg::POS_W-1:0]  parity_pos_r, parity_pos_nxt;
  logic [irpd_pkg::LEN_W-1:0]  frame_len_r, frame_len_nxt;
  logic                        rx_parity_r, rx_parity_nxt;
  logic                        last_bit_r, last_bit_nxt;

  logic       out_valid_r;
  logic       out_parity_ok_r;
  logic [7:0] out_b0_r, out_b1_r, out_b2_r, out_bits_r;
  logic       out_capture_r;
  logic [1:0] out_team_r;

  logic       emit, advance, in_ready, in_fire, cfg_wr, lb;
  logic       hit_zero, hit_one, par_calc, ok;
  logic [7:0] b0, b1, b2;
  logic signed [13:0] sw, zc, zc2, tol, lo0, hi0, lo1, hi1;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_width_r <= irpd_pkg::ZERO_WIDTH_RST;
      tolerance_r  <= irpd_pkg::TOLERANCE_RST;
      header_min_r <= irpd_pkg::HEADER_MIN_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        irpd_pkg::REG_ZERO_WIDTH: zero_width_r <= cfg_pwdata[irpd_pkg::ZERO_W-1:0];
        irpd_pkg::REG_TOLERANCE:  tolerance_r  <= cfg_pwdata[irpd_pkg::TOL_W-1:0];
        irpd_pkg::REG_HEADER_MIN: header_min_r <= cfg_pwdata[irpd_pkg::HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      irpd_pkg::REG_ZERO_WIDTH: cfg_prdata = irpd_pkg::CFG_DATA_W'(zero_width_r);
      irpd_pkg::REG_TOLERANCE:  cfg_prdata = irpd_pkg::CFG_DATA_W'(tolerance_r);
      irpd_pkg::REG_HEADER_MIN: cfg_prdata = irpd_pkg::CFG_DATA_W'(header_min_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // handshake
  assign emit     = s1_valid_r && in_frame_r && (s1_width_r == '0)
                    && (bit_index_r > irpd_pkg::SHORT_FRAME_MAX);
  assign advance  = s1_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_width_r <= in_ch.pulse_width;
    end
  end

  // bit classification
  assign sw  = $signed({2'b00, s1_width_r});
  assign zc  = $signed({3'b000, zero_width_r});
  assign zc2 = $signed({2'b00, zero_width_r, 1'b0});
  assign tol = $signed({4'b0000, tolerance_r});
  assign lo0 = zc - tol;
  assign hi0 = zc + tol;
  assign lo1 = zc2 - tol;
  assign hi1 = zc2 + tol;
  assign hit_zero = (sw > lo0) && (sw < hi0);
  assign hit_one  = (sw > lo1) && (sw < hi1);
  assign lb = hit_zero ? 1'b0 : (hit_one ? 1'b1 : last_bit_r);

  // frame state update
  always_comb begin
    in_frame_nxt   = in_frame_r;
    bit_index_nxt  = bit_index_r;
    store_nxt      = store_r;
    parity_pos_nxt = parity_pos_r;
    frame_len_nxt  = frame_len_r;
    rx_parity_nxt  = rx_parity_r;
    last_bit_nxt   = last_bit_r;
    if (!in_frame_r) begin
      if (s1_width_r > header_min_r) begin
        in_frame_nxt  = 1'b1;
        bit_index_nxt = '0;
        store_nxt     = '0;
      end
    end else if (s1_width_r == '0) begin
      in_frame_nxt = 1'b0;
    end else begin
      last_bit_nxt = lb;
      if (bit_index_r != '0 && bit_index_r == irpd_pkg::CNT_W'(parity_pos_r)) begin
        parity_pos_nxt = irpd_pkg::PARITY_POS_NONE;
        rx_parity_nxt  = lb;
      end else begin
        if (bit_index_r == '0) begin
          parity_pos_nxt = lb ? irpd_pkg::PARITY_POS_THREE : irpd_pkg::PARITY_POS_TWO;
          frame_len_nxt  = lb ? irpd_pkg::FRAME_LEN_THREE : irpd_pkg::FRAME_LEN_TWO;
        end
        for (int j = 0; j < SB; j++) begin
          if (lb && bit_index_r == irpd_pkg::CNT_W'(SB - 1 - j)) begin
            store_nxt[j] = 1'b1;
          end
        end
        if (bit_index_r != irpd_pkg::COUNT_MAX) begin
          bit_index_nxt = bit_index_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      bit_index_r  <= '0;
      store_r      <= '0;
      parity_pos_r <= irpd_pkg::PARITY_POS_NONE;
      frame_len_r  <= irpd_pkg::FRAME_LEN_NONE;
      rx_parity_r  <= 1'b0;
      last_bit_r   <= 1'b0;
    end else if (advance) begin
      in_frame_r   <= in_frame_nxt;
      bit_index_r  <= bit_index_nxt;
      store_r      <= store_nxt;
      parity_pos_r <= parity_pos_nxt;
      frame_len_r  <= frame_len_nxt;
      rx_parity_r  <= rx_parity_nxt;
      last_bit_r   <= last_bit_nxt;
    end
  end

  // result assembly
  assign b0 = store_r[SB-1  -: 8];
  assign b1 = store_r[SB-9  -: 8];
  assign b2 = store_r[SB-17 -: 8];

  always_comb begin
    case (frame_len_r)
      irpd_pkg::FRAME_LEN_TWO:   par_calc = (^b0) ^ (^b1);
      irpd_pkg::FRAME_LEN_THREE: par_calc = (^b0) ^ (^b1) ^ (^b2);
      default:                   par_calc = 1'b0;
    endcase
  end
  assign ok = (par_calc == rx_parity_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_parity_ok_r <= ok;
      out_b0_r        <= b0;
      out_b1_r        <= b1;
      out_b2_r        <= (frame_len_r == irpd_pkg::FRAME_LEN_TWO) ? 8'h00 : b2;
      out_bits_r      <= bit_index_r;
      out_capture_r   <= ok && (b0 < irpd_pkg::CAPTURE_LIMIT);
      out_team_r      <= b1[7:6];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.parity_ok     = out_parity_ok_r;
  assign out_ch.first_byte    = out_b0_r;
  assign out_ch.second_byte   = out_b1_r;
  assign out_ch.third_byte    = out_b2_r;
  assign out_ch.bits_received = out_bits_r;
  assign out_ch.is_capture    = out_capture_r;
  assign out_ch.team          = out_team_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && emit))
    else $error("input stalled without a pending result");

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> (!in_frame_r && out_valid_r && out_bits_r > irpd_pkg::SHORT_FRAME_MAX))
    else $error("result loaded without closing a long frame");

  a_parity_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (parity_pos_r == irpd_pkg::PARITY_POS_NONE) || (parity_pos_r == irpd_pkg::PARITY_POS_TWO)
    || (parity_pos_r == irpd_pkg::PARITY_POS_THREE))
    else $error("parity position out of range");

  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_frame_r && bit_index_r != '0) |-> ((frame_len_r == irpd_pkg::FRAME_LEN_TWO)
    || (frame_len_r == irpd_pkg::FRAME_LEN_THREE)))
    else $error("frame length unset after first bit");

endmodule

// ===== test/tb_ir_pulse_width_frame_decoder.sv =====
// Self-checking testbench for the IR pulse-width frame decoder.
`timescale 1ns / 100ps

module tb_ir_pulse_width_frame_decoder;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 130;
  localparam int WIDTH_MAX     = (1 << irpd_pkg::WIDTH_W) - 1;

  typedef struct packed {
    logic       parity_ok;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] bits_received;
    logic       is_capture;
    logic [1:0] team;
  } frame_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [irpd_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [irpd_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [irpd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  irpd_in_if  in_ch ();
  irpd_out_if out_ch ();

  ir_pulse_width_frame_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  logic [irpd_pkg::ZERO_W-1:0] m_zero_width;
  logic [irpd_pkg::TOL_W-1:0]  m_tolerance;
  logic [irpd_pkg::HDR_W-1:0]  m_header_min;
  bit                          m_in_frame;
  logic [irpd_pkg::CNT_W-1:0]  m_bit_index;
  irpd_pkg::store_t            m_store;
  logic [irpd_pkg::POS_W-1:0]  m_parity_pos;
  logic [irpd_pkg::LEN_W-1:0]  m_frame_len;
  bit                          m_rx_parity;
  bit                          m_last_bit;

  frame_result_t pending_frames[$];
  int            errors = 0;
  int            cycle_count = 0;
  int            item_count = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  bit            hold_req = 1'b0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 40) $display("mismatch: %s got %0d expected %0d", what, got, want);
  endtask

  function automatic bit in_window(int w, int centre, int tol);
    return (w > centre - tol) && (w < centre + tol);
  endfunction

  function automatic bit decode_pulse(input logic [irpd_pkg::WIDTH_W-1:0] w,
                                      output frame_result_t r);
    int ones;
    r = '0;
    if (!m_in_frame) begin
      if (w > m_header_min) begin
        m_in_frame  = 1'b1;
        m_bit_index = '0;
        m_store     = '0;
      end
      return 1'b0;
    end
    if (w == '0) begin
      m_in_frame = 1'b0;
      if (m_bit_index <= irpd_pkg::SHORT_FRAME_MAX) return 1'b0;
      ones = 0;
      for (int k = 0; k < int'(m_frame_len) && k < 3; k++)
        ones += $countones(m_store[irpd_pkg::STORE_BITS-8*(k+1) +: 8]);
      r.parity_ok     = ((ones % 2) == int'(m_rx_parity));
      r.first_byte    = m_store[irpd_pkg::STORE_BITS-1 -: 8];
      r.second_byte   = m_store[irpd_pkg::STORE_BITS-9 -: 8];
      r.third_byte    = (m_frame_len == irpd_pkg::FRAME_LEN_TWO) ? 8'd0
                        : m_store[irpd_pkg::STORE_BITS-17 -: 8];
      r.bits_received = m_bit_index;
      r.is_capture    = r.parity_ok && (r.first_byte < irpd_pkg::CAPTURE_LIMIT);
      r.team          = r.second_byte[7:6];
      return 1'b1;
    end
    if (in_window(int'(w), int'(m_zero_width), int'(m_tolerance))) m_last_bit = 1'b0;
    else if (in_window(int'(w), 2 * int'(m_zero_width), int'(m_tolerance))) m_last_bit = 1'b1;
    if (m_bit_index == '0) begin
      if (!m_last_bit) begin
        m_parity_pos = irpd_pkg::PARITY_POS_TWO;
        m_frame_len  = irpd_pkg::FRAME_LEN_TWO;
      end else begin
        m_parity_pos = irpd_pkg::PARITY_POS_THREE;
        m_frame_len  = irpd_pkg::FRAME_LEN_THREE;
      end
    end else if (m_bit_index == m_parity_pos) begin
      m_parity_pos = irpd_pkg::PARITY_POS_NONE;
      m_rx_parity  = m_last_bit;
      return 1'b0;
    end
    if (int'(m_bit_index) < irpd_pkg::STORE_BITS && m_last_bit)
      m_store[irpd_pkg::STORE_BITS-1-int'(m_bit_index)] = 1'b1;
    if (m_bit_index < irpd_pkg::COUNT_MAX) m_bit_index++;
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [irpd_pkg::WIDTH_W-1:0] bit_width(bit b);
    int c, lo, hi;
    c  = b ? 2 * int'(m_zero_width) : int'(m_zero_width);
    lo = c - int'(m_tolerance) + 1;
    hi = c + int'(m_tolerance) - 1;
    if (lo < 1) lo = 1;
    if (hi > WIDTH_MAX) hi = WIDTH_MAX;
    if (lo > hi) return irpd_pkg::WIDTH_W'($urandom_range(1, WIDTH_MAX));
    return irpd_pkg::WIDTH_W'($urandom_range(lo, hi));
  endfunction

  function automatic logic [irpd_pkg::WIDTH_W-1:0] header_width();
    if (int'(m_header_min) >= WIDTH_MAX) return irpd_pkg::WIDTH_W'(WIDTH_MAX);
    return irpd_pkg::WIDTH_W'($urandom_range(int'(m_header_min) + 1, WIDTH_MAX));
  endfunction

  function automatic bit good_parity(logic [23:0] data);
    return data[23] ? ^data : ^data[23:8];
  endfunction

  task automatic send_pulse(input logic [irpd_pkg::WIDTH_W-1:0] w);
    frame_result_t r;
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pulse_width <= w;
    do @(posedge clk); while (!in_ch.ready);
    item_count++;
    if (decode_pulse(w, r)) pending_frames.push_back(r);
  endtask

  task automatic send_frame(input logic [23:0] data, input bit parity, input int pulses,
                            input int noise_pct);
    int plen;
    bit b;
    plen = data[23] ? int'(irpd_pkg::PARITY_POS_THREE) : int'(irpd_pkg::PARITY_POS_TWO);
    send_pulse(header_width());
    for (int i = 0; i < pulses; i++) begin
      if (i < plen) b = data[23-i];
      else if (i == plen) b = parity;
      else b = 1'($urandom_range(0, 1));
      if (int'($urandom_range(0, 99)) < noise_pct)
        send_pulse(irpd_pkg::WIDTH_W'($urandom_range(1, WIDTH_MAX)));
      else send_pulse(bit_width(b));
    end
    send_pulse('0);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [1:0] idx,
                            input logic [irpd_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [irpd_pkg::CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= irpd_pkg::CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    logic [irpd_pkg::CFG_DATA_W-1:0] rd;
    cfg_access(1'b1, idx, irpd_pkg::CFG_DATA_W'(value), rd);
    case (idx)
      irpd_pkg::REG_ZERO_WIDTH: m_zero_width = irpd_pkg::ZERO_W'(value);
      irpd_pkg::REG_TOLERANCE:  m_tolerance  = irpd_pkg::TOL_W'(value);
      irpd_pkg::REG_HEADER_MIN: m_header_min = irpd_pkg::HDR_W'(value);
      default: ;
    endcase
    cfg_access(1'b0, idx, '0, rd);
    if (rd != irpd_pkg::CFG_DATA_W'(value)) report("register readback", int'(rd), value);
  endtask

  task automatic set_config(input int zw, input int tol, input int hdr);
    settle();
    write_reg(irpd_pkg::REG_ZERO_WIDTH, zw);
    write_reg(irpd_pkg::REG_TOLERANCE, tol);
    write_reg(irpd_pkg::REG_HEADER_MIN, hdr);
  endtask

  task automatic test_register_access();
    logic [irpd_pkg::CFG_DATA_W-1:0] rd;
    logic [1:0]                      regs [3];
    int                              resets [3];
    regs   = '{irpd_pkg::REG_ZERO_WIDTH, irpd_pkg::REG_TOLERANCE, irpd_pkg::REG_HEADER_MIN};
    resets = '{int'(irpd_pkg::ZERO_WIDTH_RST), int'(irpd_pkg::TOLERANCE_RST),
               int'(irpd_pkg::HEADER_MIN_RST)};
    foreach (regs[i]) begin
      cfg_access(1'b0, regs[i], '0, rd);
      if (rd != irpd_pkg::CFG_DATA_W'(resets[i]))
        report("register reset value", int'(rd), resets[i]);
    end
    set_config(2047, 1023, 4095);
    set_config(0, 0, 0);
    set_config(int'(irpd_pkg::ZERO_WIDTH_RST), int'(irpd_pkg::TOLERANCE_RST),
               int'(irpd_pkg::HEADER_MIN_RST));
  endtask

  task automatic test_idle_items();
    send_pulse('0);
    send_pulse(12'd1);
    send_pulse(irpd_pkg::HEADER_MIN_RST);
    send_pulse(12'd1799);
    send_pulse('0);
    settle();
  endtask

  task automatic test_window_edges();
    int widths [] = '{1801, 401, 799, 1001, 1399, 400, 800, 1000, 1400, 4095, 1, 900,
                      2047, 3000, 600, 1200, 1200, 601, 0};
    foreach (widths[i]) send_pulse(irpd_pkg::WIDTH_W'(widths[i]));
    settle();
  endtask

  task automatic test_two_byte_frames();
    send_frame(24'h12C500, good_parity(24'h12C500), 17, 0);
    send_frame(24'h7F0100, !good_parity(24'h7F0100), 17, 0);
    send_frame(24'h00FF00, good_parity(24'h00FF00), 17, 0);
    settle();
  endtask

  task automatic test_three_byte_frames();
    send_frame(24'hA5C33C, good_parity(24'hA5C33C), 25, 0);
    send_frame(24'hFFFFFF, !good_parity(24'hFFFFFF), 25, 0);
    send_frame(24'h800000, good_parity(24'h800000), 25, 0);
    settle();
  endtask

  task automatic test_short_frames();
    send_frame(24'h2A5500, 1'b0, 15, 0);
    send_frame(24'h2A5500, 1'b0, 16, 0);
    send_frame(24'hC3A55A, 1'b1, 20, 0);
    send_frame(24'h000000, 1'b0, 0, 0);
    settle();
  endtask

  task automatic test_long_frames();
    send_frame(24'h3C6600, good_parity(24'h3C6600), 30, 0);
    send_frame(24'h9988AA, good_parity(24'h9988AA), 40, 0);
    send_frame(24'hF0F0F0, good_parity(24'hF0F0F0), 270, 0);
    settle();
  endtask

  task automatic test_stale_last_bit();
    send_frame(24'hFFFFFF, good_parity(24'hFFFFFF), 26, 0);
    send_pulse(header_width());
    send_pulse(12'd900);
    for (int i = 0; i < 20; i++)
      send_pulse((i == 7) ? irpd_pkg::WIDTH_W'(WIDTH_MAX) : bit_width(1'($urandom_range(0, 1))));
    send_pulse('0);
    settle();
  endtask

  task automatic test_result_backpressure();
    logic [23:0] data;
    settle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 1'b1;
    repeat (5) begin
      data     = 24'($urandom);
      data[23] = 1'b0;
      send_frame(data, good_parity(data), 17, 0);
    end
    settle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          zw, tol, hdr, target, r;
    logic [23:0] data;
    bit          parity;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_config(int'(irpd_pkg::ZERO_WIDTH_RST), int'(irpd_pkg::TOLERANCE_RST),
                      int'(irpd_pkg::HEADER_MIN_RST));
        1: set_config(0, 0, 0);
        2: set_config(2047, 1023, 4095);
        3: set_config(2047, 1023, 0);
        4: set_config(1, 1023, 100);
        default: begin
          zw  = $urandom_range(100, 1500);
          tol = $urandom_range(1, zw / 3 + 1);
          hdr = $urandom_range((2 * zw + tol > 4000) ? 4000 : 2 * zw + tol, 4094);
          set_config(zw, tol, hdr);
        end
      endcase
      tx_idle_on = (phase % 3) != 1;
      rx_idle_on = (phase % 4) != 2;
      target = item_count + ((phase == 2) ? 30 : PHASE_ITEMS);
      while (item_count < target) begin
        r      = $urandom_range(0, 99);
        data   = 24'($urandom);
        parity = ($urandom_range(0, 3) == 0) ? !good_parity(data) : good_parity(data);
        if (r < 15) begin
          repeat ($urandom_range(1, 3))
            send_pulse(irpd_pkg::WIDTH_W'($urandom_range(0, int'(m_header_min))));
        end else if (r < 50) begin
          data[23] = 1'b0;
          parity   = ($urandom_range(0, 3) == 0) ? !good_parity(data) : good_parity(data);
          send_frame(data, parity, $urandom_range(17, 19), ($urandom_range(0, 3) == 0) ? 4 : 0);
        end else if (r < 80) begin
          data[23] = 1'b1;
          parity   = ($urandom_range(0, 3) == 0) ? !good_parity(data) : good_parity(data);
          send_frame(data, parity, $urandom_range(25, 27), ($urandom_range(0, 3) == 0) ? 4 : 0);
        end else if (r < 88) begin
          send_frame(data, parity, $urandom_range(0, 24), 0);
        end else if (r < 95) begin
          send_frame(data, parity, $urandom_range(26, 40), 0);
        end else if (r < 99) begin
          send_frame(data, parity, $urandom_range(5, 30), 30);
        end else begin
          send_frame(data, parity, $urandom_range(256, 262), 0);
        end
      end
    end
    settle();
  endtask

  initial begin
    forever begin
      int n;
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
      end else begin
        n = 0;
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_frames.size() == 0) begin
        report("result with nothing pending", 1, 0);
      end else begin
        want = pending_frames.pop_front();
        if (out_ch.parity_ok !== want.parity_ok)
          report("parity_ok", int'(out_ch.parity_ok), int'(want.parity_ok));
        if (out_ch.first_byte !== want.first_byte)
          report("first_byte", int'(out_ch.first_byte), int'(want.first_byte));
        if (out_ch.second_byte !== want.second_byte)
          report("second_byte", int'(out_ch.second_byte), int'(want.second_byte));
        if (out_ch.third_byte !== want.third_byte)
          report("third_byte", int'(out_ch.third_byte), int'(want.third_byte));
        if (out_ch.bits_received !== want.bits_received)
          report("bits_received", int'(out_ch.bits_received), int'(want.bits_received));
        if (out_ch.is_capture !== want.is_capture)
          report("is_capture", int'(out_ch.is_capture), int'(want.is_capture));
        if (out_ch.team !== want.team)
          report("team", int'(out_ch.team), int'(want.team));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.pulse_width <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    m_zero_width      = irpd_pkg::ZERO_WIDTH_RST;
    m_tolerance       = irpd_pkg::TOLERANCE_RST;
    m_header_min      = irpd_pkg::HEADER_MIN_RST;
    m_in_frame        = 1'b0;
    m_bit_index       = '0;
    m_store           = '0;
    m_parity_pos      = irpd_pkg::PARITY_POS_NONE;
    m_frame_len       = irpd_pkg::FRAME_LEN_NONE;
    m_rx_parity       = 1'b0;
    m_last_bit        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_idle_items();
    test_window_edges();
    test_two_byte_frames();
    test_three_byte_frames();
    test_short_frames();
    test_long_frames();
    test_stale_last_bit();
    test_result_backpressure();
    test_random_traffic();

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/irpd_pkg.sv
rtl/irpd_in_if.sv
rtl/irpd_out_if.sv
rtl/ir_pulse_width_frame_decoder.sv
test/tb_ir_pulse_width_frame_decoder.sv
